### rtl/pbsl_pkg.sv
// Shared types and constants for the packed block state lookup.
// No dependencies; imported by every module of the block.
package pbsl_pkg;

    typedef enum logic [2:0] {
        ACT_READ = 3'd0,
        ACT_WORD = 3'd1,
        ACT_PAL  = 3'd2,
        ACT_HDR  = 3'd3,
        ACT_MASK = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HDR,
        ST_W0,
        ST_W1,
        ST_W2,
        ST_PAL
    } back_state_t;

    localparam int IN_DATA_W     = 200;
    localparam int IN_USER_W     = 3;
    localparam int OUT_DATA_W    = 16;
    localparam int OUT_USER_W    = 2;
    localparam int CHUNK_W       = 22;
    localparam int U_W           = 24;   // biased chunk coordinate, never negative
    localparam int RECIP_SHIFT   = 30;
    localparam int MAX_SLOT_BITS = 12;   // enough for a 64 x 64 grid
    localparam int LOC_W         = 12;   // y, z, x inside a section, 4 bits each
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = 2;

    // one classified word on its way from front to back
    typedef struct packed {
        action_t                    act;
        logic [MAX_SLOT_BITS-1:0]   slot;
        logic [3:0]                 snum;
        logic [LOC_W-1:0]           loc_pos;
        logic [9:0]                 word_index;
        logic [7:0]                 palette_index;
        logic [63:0]                write_value;
        logic [3:0]                 entry_bits;
        logic                       palette_used;
    } queue_entry_t;

    typedef struct packed {
        logic         push;
        queue_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic         empty;
        queue_entry_t entry;
    } q_head_t;

endpackage

### rtl/pbsl_front.sv
// Front end: accepts input words, finds the chunk slot (floor by 16, wrap
// modulo the grid side) and the section, and pushes the item into the queue.
// Depends on pbsl_pkg.
module pbsl_front
    import pbsl_pkg::*;
#(
    parameter int GRID_SIDE = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  q_full,
    output q_push_t               q_out
);

    localparam int GRID_BITS = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int SLOT_BITS = (GRID_SIDE > 1) ? $clog2(GRID_SIDE * GRID_SIDE) : 1;
    localparam longint OFFSET = GRID_SIDE * ((2 ** 21 + GRID_SIDE - 1) / GRID_SIDE);
    localparam longint RECIP  = (64'd1 << RECIP_SHIFT) / GRID_SIDE;
    localparam int PROD_W = U_W + RECIP_SHIFT + 1;

    logic                   adv;
    logic signed [25:0]     wx, wz;
    logic [7:0]             wy;
    logic [CHUNK_W-1:0]     cx_in, cz_in;
    logic [U_W-1:0]         ux_in, uz_in;
    action_t                act_in;
    queue_entry_t           entry_in;
    logic [PROD_W-1:0]      px, pz;
    logic [U_W-1:0]         dx, dz;
    logic [GRID_BITS-1:0]   rx_next, rz_next;
    logic [SLOT_BITS-1:0]   slot;

    logic                   a_valid_reg, b_valid_reg, c_valid_reg;
    queue_entry_t           a_entry_reg, b_entry_reg, c_entry_reg;
    logic [U_W-1:0]         a_ux_reg, a_uz_reg, b_ux_reg, b_uz_reg;
    logic [U_W-1:0]         b_qx_reg, b_qz_reg;
    logic [GRID_BITS-1:0]   c_rx_reg, c_rz_reg;

    assign adv      = !q_full;
    assign s_tready = adv;

    assign act_in = action_t'(s_tuser[2:0]);
    assign wx     = signed'(s_tdata[25:0]);
    assign wy     = s_tdata[33:26];
    assign wz     = signed'(s_tdata[59:34]);

    always_comb
    begin
        if (act_in == ACT_READ)
        begin
            cx_in = CHUNK_W'(wx >>> 4);
            cz_in = CHUNK_W'(wz >>> 4);
        end
        else
        begin
            cx_in = s_tdata[81:60];
            cz_in = s_tdata[103:82];
        end
    end

    // bias to a positive value; the bias is a multiple of the grid side
    assign ux_in = {{(U_W-CHUNK_W){cx_in[CHUNK_W-1]}}, cx_in} + U_W'(OFFSET);
    assign uz_in = {{(U_W-CHUNK_W){cz_in[CHUNK_W-1]}}, cz_in} + U_W'(OFFSET);

    always_comb
    begin
        entry_in               = '0;
        entry_in.act           = act_in;
        entry_in.snum          = (act_in == ACT_READ) ? wy[7:4] : s_tdata[107:104];
        entry_in.loc_pos       = {wy[3:0], s_tdata[37:34], s_tdata[3:0]};
        entry_in.word_index    = s_tdata[117:108];
        entry_in.palette_index = s_tdata[125:118];
        entry_in.write_value   = s_tdata[189:126];
        entry_in.entry_bits    = s_tdata[193:190];
        entry_in.palette_used  = s_tdata[194];
    end

    // quotient by reciprocal, may come out one low
    assign px = PROD_W'(a_ux_reg) * PROD_W'(RECIP);
    assign pz = PROD_W'(a_uz_reg) * PROD_W'(RECIP);

    assign dx = b_ux_reg - U_W'(b_qx_reg * U_W'(GRID_SIDE));
    assign dz = b_uz_reg - U_W'(b_qz_reg * U_W'(GRID_SIDE));
    assign rx_next = (dx >= U_W'(GRID_SIDE)) ? GRID_BITS'(dx - U_W'(GRID_SIDE))
                                             : GRID_BITS'(dx);
    assign rz_next = (dz >= U_W'(GRID_SIDE)) ? GRID_BITS'(dz - U_W'(GRID_SIDE))
                                             : GRID_BITS'(dz);

    assign slot = SLOT_BITS'(SLOT_BITS'(c_rx_reg) * SLOT_BITS'(GRID_SIDE))
                + SLOT_BITS'(c_rz_reg);

    always_comb
    begin
        q_out.entry      = c_entry_reg;
        q_out.entry.slot = MAX_SLOT_BITS'(slot);
        unique case (c_entry_reg.act)
            ACT_READ, ACT_WORD, ACT_PAL, ACT_HDR, ACT_MASK: q_out.push = c_valid_reg && adv;
            default:                                        q_out.push = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_entry_reg <= entry_in;
            a_ux_reg    <= ux_in;
            a_uz_reg    <= uz_in;
            b_entry_reg <= a_entry_reg;
            b_ux_reg    <= a_ux_reg;
            b_uz_reg    <= a_uz_reg;
            b_qx_reg    <= px[RECIP_SHIFT +: U_W];
            b_qz_reg    <= pz[RECIP_SHIFT +: U_W];
            c_entry_reg <= b_entry_reg;
            c_rx_reg    <= rx_next;
            c_rz_reg    <= rz_next;
        end
    end

endmodule

### rtl/pbsl_fifo.sv
// Short queue between front and back so each side stalls on its own.
// Depends on pbsl_pkg.
module pbsl_fifo
    import pbsl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_push_t q_in,
    output logic    full,
    input  logic    pop,
    output q_head_t q_head
);

    queue_entry_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]     count_reg;
    logic                 do_push, do_pop;

    assign full          = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign q_head.empty  = (count_reg == '0);
    assign q_head.entry  = mem_reg[rd_ptr_reg];
    assign do_push       = q_in.push && !full;
    assign do_pop        = pop && !q_head.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= q_in.entry;
    end

endmodule

### rtl/pbsl_back.sv
// Back end: section storage (packed words, palettes, headers, masks), the
// write path and the read sequencer with its output register.
// Depends on pbsl_pkg.
module pbsl_back
    import pbsl_pkg::*;
#(
    parameter int GRID_SIDE         = 2,
    parameter int MAX_ENTRY_BITS    = 14,
    parameter int PALETTE_DEPTH     = 256,
    parameter int WORDS_PER_SECTION = 896
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  q_head_t                q_head,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic [OUT_USER_W-1:0]  m_tuser
);

    localparam int SLOT_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SECT_COUNT = SLOT_COUNT * 16;
    localparam int SECT_BITS  = SLOT_BITS + 4;
    localparam int WORD_DEPTH = SECT_COUNT * WORDS_PER_SECTION;
    localparam int WA_BITS    = $clog2(WORD_DEPTH);
    localparam int PAL_ALL    = SECT_COUNT * PALETTE_DEPTH;
    localparam int PA_BITS    = $clog2(PAL_ALL);
    localparam int PL_BITS    = $clog2(PALETTE_DEPTH + 1);
    localparam int EW_BITS    = $clog2(MAX_ENTRY_BITS + 1);
    localparam int HDR_W      = 1 + EW_BITS + PL_BITS;
    localparam int BP_BITS    = LOC_W + EW_BITS;
    localparam int WX_BITS    = BP_BITS - 6;
    localparam int CMP_W      = ((MAX_ENTRY_BITS > PL_BITS) ? MAX_ENTRY_BITS : PL_BITS) + 1;
    localparam int IDX_W      = MAX_ENTRY_BITS;

    // storage
    logic [63:0]         word_mem [WORD_DEPTH];
    logic [15:0]         pal_mem  [PAL_ALL];
    logic [HDR_W-1:0]    hdr_mem  [SECT_COUNT];
    logic [15:0]         mask_mem [SLOT_COUNT];

    logic [63:0]         word_q;
    logic [15:0]         pal_q;
    logic [HDR_W-1:0]    hdr_q;
    logic [15:0]         mask_q;

    back_state_t         state_reg, state_next;
    logic [SECT_BITS-1:0] clr_cnt_reg;
    queue_entry_t        cur_reg;
    logic [WA_BITS-1:0]  base_reg, base_next;
    logic [PA_BITS-1:0]  pal_base_reg, pal_base_next;
    logic [BP_BITS-1:0]  bitpos_reg, bitpos_next;
    logic [63:0]         w0_reg;
    logic                w0_oob_reg, w0_oob_next, w1_oob_reg, w1_oob_next;
    logic                pen_reg;
    logic [EW_BITS-1:0]  ew_reg;
    logic [PL_BITS-1:0]  plen_reg;
    logic                o_valid_reg, o_valid_next;
    logic [OUT_DATA_W-1:0] o_data_reg, o_data_next;
    logic [OUT_USER_W-1:0] o_user_reg, o_user_next;
    logic                load_cur, load_hdr, load_w0, load_pos;

    // head entry decode
    queue_entry_t        hd;
    logic [SECT_BITS-1:0] hd_sect, cur_sect;
    logic [EW_BITS-1:0]  hd_ew;
    logic [PL_BITS-1:0]  hd_plen;

    // memory ports
    logic                word_we, pal_we, hdr_we, mask_we;
    logic [WA_BITS-1:0]  word_waddr, word_raddr;
    logic [PA_BITS-1:0]  pal_waddr, pal_raddr;
    logic [SECT_BITS-1:0] hdr_waddr;
    logic [HDR_W-1:0]    hdr_wdata;
    logic [SLOT_BITS-1:0] mask_waddr;
    logic [15:0]         mask_wdata;

    // extraction
    logic [WX_BITS-1:0]  widx;
    logic [5:0]          pos;
    logic [127:0]        pair;
    logic [IDX_W:0]      width_mask;
    logic [IDX_W-1:0]    idx;

    assign hd       = q_head.entry;
    assign hd_sect  = {hd.slot[SLOT_BITS-1:0], hd.snum};
    assign cur_sect = {cur_reg.slot[SLOT_BITS-1:0], cur_reg.snum};

    always_comb
    begin
        if (hd.entry_bits == 4'd0)
            hd_ew = EW_BITS'(1);
        else if ({1'b0, hd.entry_bits} > 5'(MAX_ENTRY_BITS))
            hd_ew = EW_BITS'(MAX_ENTRY_BITS);
        else
            hd_ew = EW_BITS'(hd.entry_bits);
        hd_plen = (hd.write_value > 64'(PALETTE_DEPTH)) ? PL_BITS'(PALETTE_DEPTH)
                                                        : hd.write_value[PL_BITS-1:0];
    end

    assign widx = bitpos_reg[BP_BITS-1:6];
    assign pos  = bitpos_reg[5:0];
    assign pair = {(w1_oob_reg ? 64'd0 : word_q), (w0_oob_reg ? 64'd0 : w0_reg)} >> pos;
    assign width_mask = ((IDX_W+1)'(1) << ew_reg) - 1'b1;
    assign idx  = pair[IDX_W-1:0] & width_mask[IDX_W-1:0];

    assign word_waddr = WA_BITS'(hd_sect * WA_BITS'(WORDS_PER_SECTION)) + WA_BITS'(hd.word_index);
    assign pal_waddr  = PA_BITS'(hd_sect * PA_BITS'(PALETTE_DEPTH)) + PA_BITS'(hd.palette_index);
    assign base_next     = WA_BITS'(hd_sect * WA_BITS'(WORDS_PER_SECTION));
    assign pal_base_next = PA_BITS'(hd_sect * PA_BITS'(PALETTE_DEPTH));
    assign pal_raddr     = pal_base_reg + PA_BITS'(idx);
    assign bitpos_next   = BP_BITS'(cur_reg.loc_pos) * BP_BITS'(hdr_q[PL_BITS +: EW_BITS]);

    always_comb
    begin
        state_next   = state_reg;
        pop          = 1'b0;
        load_cur     = 1'b0;
        load_hdr     = 1'b0;
        load_pos     = 1'b0;
        load_w0      = 1'b0;
        word_we      = 1'b0;
        pal_we       = 1'b0;
        hdr_we       = 1'b0;
        mask_we      = 1'b0;
        hdr_waddr    = hd_sect;
        hdr_wdata    = {hd.palette_used, hd_ew, hd_plen};
        mask_waddr   = hd.slot[SLOT_BITS-1:0];
        mask_wdata   = hd.write_value[15:0];
        word_raddr   = base_reg + WA_BITS'(widx);
        w0_oob_next  = w0_oob_reg;
        w1_oob_next  = w1_oob_reg;
        o_valid_next = o_valid_reg && !m_tready;
        o_data_next  = o_data_reg;
        o_user_next  = o_user_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                hdr_we     = 1'b1;
                hdr_waddr  = clr_cnt_reg;
                hdr_wdata  = {1'b0, EW_BITS'(4), PL_BITS'(0)};
                mask_we    = 1'b1;
                mask_waddr = clr_cnt_reg[SECT_BITS-1:4];
                mask_wdata = '0;
                if (clr_cnt_reg == SECT_BITS'(SECT_COUNT - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (!q_head.empty)
                begin
                    unique case (hd.act)
                        ACT_READ:
                        begin
                            if (!o_valid_reg)
                            begin
                                pop        = 1'b1;
                                load_cur   = 1'b1;
                                state_next = ST_HDR;
                            end
                        end
                        ACT_WORD:
                        begin
                            pop     = 1'b1;
                            word_we = ({1'b0, hd.word_index} < 11'(WORDS_PER_SECTION));
                        end
                        ACT_PAL:
                        begin
                            pop    = 1'b1;
                            pal_we = (9'(hd.palette_index) < 9'(PALETTE_DEPTH));
                        end
                        ACT_HDR:
                        begin
                            pop    = 1'b1;
                            hdr_we = 1'b1;
                        end
                        ACT_MASK:
                        begin
                            pop     = 1'b1;
                            mask_we = 1'b1;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_HDR:
            begin
                load_hdr = 1'b1;
                if (!mask_q[cur_reg.snum])
                begin
                    o_valid_next = 1'b1;
                    o_data_next  = '0;
                    o_user_next  = '0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    load_pos   = 1'b1;
                    state_next = ST_W0;
                end
            end
            ST_W0:
            begin
                w0_oob_next = (32'(widx) >= WORDS_PER_SECTION);
                w1_oob_next = (32'(widx) + 32'd1 >= WORDS_PER_SECTION);
                state_next  = ST_W1;
            end
            ST_W1:
            begin
                load_w0    = 1'b1;
                word_raddr = base_reg + WA_BITS'(widx) + 1'b1;
                state_next = ST_W2;
            end
            ST_W2:
            begin
                if (!pen_reg)
                begin
                    o_valid_next = 1'b1;
                    o_data_next  = OUT_DATA_W'(idx);
                    o_user_next  = 2'b01;
                    state_next   = ST_IDLE;
                end
                else if (CMP_W'(idx) >= CMP_W'(plen_reg))
                begin
                    o_valid_next = 1'b1;
                    o_data_next  = '0;
                    o_user_next  = 2'b11;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_PAL;
                end
            end
            ST_PAL:
            begin
                o_valid_next = 1'b1;
                o_data_next  = pal_q;
                o_user_next  = 2'b01;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            o_valid_reg <= o_valid_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        o_data_reg <= o_data_next;
        o_user_reg <= o_user_next;
        w0_oob_reg <= w0_oob_next;
        w1_oob_reg <= w1_oob_next;
        if (load_cur)
        begin
            cur_reg      <= hd;
            base_reg     <= base_next;
            pal_base_reg <= pal_base_next;
        end
        if (load_hdr)
        begin
            pen_reg  <= hdr_q[HDR_W-1];
            ew_reg   <= hdr_q[PL_BITS +: EW_BITS];
            plen_reg <= hdr_q[PL_BITS-1:0];
        end
        if (load_pos)
            bitpos_reg <= bitpos_next;
        if (load_w0)
            w0_reg <= word_q;
    end

    always_ff @(posedge clk)
    begin
        if (word_we)
            word_mem[word_waddr] <= hd.write_value;
        word_q <= word_mem[word_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[pal_waddr] <= hd.write_value[15:0];
        pal_q <= pal_mem[pal_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
            hdr_mem[hdr_waddr] <= hdr_wdata;
        hdr_q <= hdr_mem[(state_reg == ST_IDLE) ? hd_sect : cur_sect];
    end

    always_ff @(posedge clk)
    begin
        if (mask_we)
            mask_mem[mask_waddr] <= mask_wdata;
        mask_q <= mask_mem[(state_reg == ST_IDLE) ? hd.slot[SLOT_BITS-1:0]
                                                  : cur_reg.slot[SLOT_BITS-1:0]];
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = o_user_reg;

endmodule

### rtl/packed_block_state_lookup.sv
// Packed block state lookup: reads of bit-packed palette sections in a wrapped chunk grid.
// A read passes three front stages and the queue, then the header read, two word reads
// and, when paletted and in range, the palette read; an absent section ends after the
// header. The back end pops write words while idle; a read holds the sequencer until its
// result is registered and waits while the previous result is not taken. After reset a
// clearing pass over all GRID_SIDE*GRID_SIDE*16 sections resets headers and masks;
// input words are queued meanwhile. Control state resets asynchronously on rst_n low.
// Depends on pbsl_pkg, pbsl_front, pbsl_fifo, pbsl_back.
module packed_block_state_lookup
    import pbsl_pkg::*;
#(
    parameter int GRID_SIDE         = 2,
    parameter int MAX_ENTRY_BITS    = 14,
    parameter int PALETTE_DEPTH     = 256,
    parameter int WORDS_PER_SECTION = 896
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // world_x[25:0] world_y[33:26] world_z[59:34] chunk_x[81:60] chunk_z[103:82]
    // section_number[107:104] word_index[117:108] palette_index[125:118]
    // write_value[189:126] entry_bits[193:190] palette_used[194], zero fill
    input  logic [IN_DATA_W-1:0]   s_tdata,
    // action[2:0]
    input  logic [IN_USER_W-1:0]   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // block_id[15:0]
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // section_present[0] palette_range_error[1]
    output logic [OUT_USER_W-1:0]  m_tuser
);

    q_push_t q_push;
    q_head_t q_head;
    logic    q_full;
    logic    q_pop;

    // front: chunk wrap and section classification
    pbsl_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_out    (q_push)
    );

    // queue decouples front stalls from back memory work
    pbsl_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_in   (q_push),
        .full   (q_full),
        .pop    (q_pop),
        .q_head (q_head)
    );

    // back: storage, writes and the read sequencer
    pbsl_back #(
        .GRID_SIDE         (GRID_SIDE),
        .MAX_ENTRY_BITS    (MAX_ENTRY_BITS),
        .PALETTE_DEPTH     (PALETTE_DEPTH),
        .WORDS_PER_SECTION (WORDS_PER_SECTION)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_head   (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### test/tb_packed_block_state_lookup.sv
// Testbench for packed_block_state_lookup: drives write and read words on the input
// stream and checks each lookup result against a behavioral model of the grid storage.
// Depends on pbsl_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_packed_block_state_lookup;
    import pbsl_pkg::*;

    localparam int GRID = 2;
    localparam int MAXB = 14;
    localparam int PDEPTH = 256;
    localparam int WPS = 896;
    localparam int NSECT = GRID * GRID * 16;
    localparam int STALL_LIMIT = 20000;
    localparam int FILL_WORDS = 66;
    localparam int FILL_PALS = 32;
    localparam int WORD_TARGET = 1300;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic [IN_USER_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    packed_block_state_lookup dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // shadow copy of the block's storage
    logic [63:0] grid_words [NSECT*WPS];
    bit          word_written [NSECT*WPS];
    logic [15:0] grid_palette [NSECT*PDEPTH];
    bit          pal_written [NSECT*PDEPTH];
    int unsigned pal_len [NSECT];
    int unsigned ent_bits [NSECT];
    bit          pal_on [NSECT];
    logic [15:0] chunk_mask [GRID*GRID];

    // expected lookups: {error, present, block_id}
    logic [17:0] lookup_q [$];
    int errors;
    int idle_pct;
    int stall_cycles;
    int words_sent;
    bit done;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned wrap_coord(longint c);
        longint r;
        r = c % GRID;
        if (r < 0)
            r += GRID;
        return r;
    endfunction

    // floor by 16 of a signed coordinate is an arithmetic shift
    function automatic int unsigned slot_from_world(logic signed [25:0] x, logic signed [25:0] z);
        return wrap_coord(longint'(x >>> 4)) * GRID + wrap_coord(longint'(z >>> 4));
    endfunction

    function automatic logic [63:0] word_of(int unsigned sect, int unsigned w);
        if (w >= WPS)
            return 64'd0;
        return grid_words[sect*WPS + w];
    endfunction

    // the read that a world position would cause: which words and which palette slot
    function automatic bit read_is_defined(logic signed [25:0] x, logic [7:0] y,
                                           logic signed [25:0] z);
        int unsigned slot, sect, b, bp, w, idx;
        logic [127:0] pair;
        slot = slot_from_world(x, z);
        if (!chunk_mask[slot][y[7:4]])
            return 1;
        sect = slot*16 + y[7:4];
        b = ent_bits[sect];
        bp = {y[3:0], z[3:0], x[3:0]} * b;
        w = bp >> 6;
        if (w < WPS && !word_written[sect*WPS + w])
            return 0;
        if ((bp & 63) + b > 64 && w + 1 < WPS && !word_written[sect*WPS + w + 1])
            return 0;
        if (!pal_on[sect])
            return 1;
        pair = {word_of(sect, w + 1), word_of(sect, w)};
        idx = (pair >> (bp & 63)) & ((1 << b) - 1);
        return idx >= pal_len[sect] || pal_written[sect*PDEPTH + idx];
    endfunction

    // apply one word to the shadow state; returns 1 and the lookup when it is a read
    function automatic bit apply_word(logic [2:0] act, logic [IN_DATA_W-1:0] d,
                                      output logic [17:0] res);
        logic signed [25:0] x, z;
        logic [7:0] y;
        int unsigned slot, sect, b, bp, w, idx;
        logic [127:0] pair;
        logic [15:0] blk;
        logic err;
        x = d[25:0]; y = d[33:26]; z = d[59:34];
        res = '0;
        if (act == ACT_READ)
        begin
            slot = slot_from_world(x, z);
            if (!chunk_mask[slot][y[7:4]])
                return 1;
            sect = slot*16 + y[7:4];
            b = ent_bits[sect];
            bp = {y[3:0], z[3:0], x[3:0]} * b;
            w = bp >> 6;
            pair = {word_of(sect, w + 1), word_of(sect, w)};
            idx = (pair >> (bp & 63)) & ((1 << b) - 1);
            err = 0;
            if (!pal_on[sect])
                blk = idx[15:0];
            else if (idx >= pal_len[sect])
            begin
                blk = 0;
                err = 1;
            end
            else
                blk = grid_palette[sect*PDEPTH + idx];
            res = {err, 1'b1, blk};
            return 1;
        end
        slot = wrap_coord(longint'($signed(d[81:60]))) * GRID
             + wrap_coord(longint'($signed(d[103:82])));
        sect = slot*16 + d[107:104];
        case (act)
            ACT_WORD:
                if (d[117:108] < WPS)
                begin
                    grid_words[sect*WPS + d[117:108]] = d[189:126];
                    word_written[sect*WPS + d[117:108]] = 1;
                end
            ACT_PAL:
            begin
                grid_palette[sect*PDEPTH + d[125:118]] = d[141:126];
                pal_written[sect*PDEPTH + d[125:118]] = 1;
            end
            ACT_HDR:
            begin
                b = d[193:190];
                ent_bits[sect] = b == 0 ? 1 : (b > MAXB ? MAXB : b);
                pal_on[sect] = d[194];
                pal_len[sect] = d[189:126] > PDEPTH ? PDEPTH : d[189:126];
            end
            ACT_MASK: chunk_mask[slot] = d[141:126];
            default: ;
        endcase
        return 0;
    endfunction

    // one word on the input stream, with random idle cycles ahead of it;
    // valid stays up after the accept until the next word or idle cycle replaces it
    task automatic send_word(logic [2:0] act, logic [IN_DATA_W-1:0] d);
        logic [17:0] res;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= act;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (apply_word(act, d, res))
            lookup_q.push_back(res);
        @(negedge clk);
    endtask

    function automatic logic [IN_DATA_W-1:0] pack_write(int cx, int cz, int sn,
                                                        int wi, int pi, logic [63:0] v,
                                                        int eb, bit pu);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[81:60] = cx; d[103:82] = cz; d[107:104] = sn;
        d[117:108] = wi; d[125:118] = pi; d[189:126] = v;
        d[193:190] = eb; d[194] = pu;
        return d;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_read(logic [25:0] x, logic [7:0] y,
                                                       logic [25:0] z);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[25:0] = x; d[33:26] = y; d[59:34] = z;
        return d;
    endfunction

    // read sent only if its location is defined; bits 60 to 194 are random junk, bits above stay zero
    task automatic send_read(logic [25:0] x, logic [7:0] y, logic [25:0] z);
        logic [IN_DATA_W-1:0] d;
        if (!read_is_defined(x, y, z))
            return;
        d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        d[IN_DATA_W-1:195] = '0;
        d[59:0] = pack_read(x, y, z);
        send_word(ACT_READ, d);
    endtask

    function automatic logic [25:0] rand_coord();
        case ($urandom_range(3))
            0: return 26'h2000000 + $urandom_range(63);
            1: return 26'h1ffffff - $urandom_range(63);
            2: return $urandom_range(63);
            default: return {$urandom, $urandom} & 26'h3ffffff;
        endcase
    endfunction

    task automatic fill_section(int cx, int cz, int sn, int eb, bit pu, int plen);
        int b;
        b = eb == 0 ? 1 : (eb > MAXB ? MAXB : eb);
        send_word(ACT_HDR, pack_write(cx, cz, sn, 0, 0, plen, eb, pu));
        // leading words and palette slots only; reads beyond them are skipped
        for (int w = 0; w < (4096*b + 63)/64 + 1 && w < FILL_WORDS && w < WPS; w++)
            send_word(ACT_WORD, pack_write(cx, cz, sn, w, 0, {$urandom, $urandom}, 0, 0));
        for (int p = 0; p < (1 << b) && p < FILL_PALS && p < PDEPTH; p++)
            send_word(ACT_PAL, pack_write(cx, cz, sn, 0, p, {$urandom, $urandom}, 0, 0));
    endtask

    task automatic test_absent_sections();
        send_read(26'h0, 8'h0, 26'h0);
        send_read(26'h1ffffff, 8'hff, 26'h2000000);
        send_word(ACT_MASK, pack_write(1, -1, 0, 0, 0, 64'hffff_ffff_ffff_0000, 0, 0));
        send_read(26'h10, 8'h80, 26'h3fffff0);
    endtask

    task automatic test_unpaletted_width_extremes();
        fill_section(0, 0, 0, 0, 0, 0);
        fill_section(0, 0, 15, 15, 0, 0);
        send_word(ACT_MASK, pack_write(2, -2, 0, 0, 0, 64'h8001, 0, 0));
        send_read(26'h0, 8'h00, 26'h0);
        send_read(26'h0f, 8'h0f, 26'h0f);
        send_read(26'h0f, 8'hf0, 26'h0f);
        // entry straddles two words
        send_read(26'h4, 8'hf0, 26'h0);
        // unknown actions and out-of-range word indices are dropped
        send_word(3'd5, pack_write(0, 0, 15, 0, 0, 64'h0, 1, 1));
        send_word(3'd7, '1);
        send_word(ACT_WORD, pack_write(0, 0, 15, 1023, 0, 64'h0, 0, 0));
        send_read(26'h0f, 8'hf0, 26'h0f);
    endtask

    task automatic test_palette_range();
        fill_section(1, 0, 3, 5, 1, 10);
        fill_section(1, 1, 4, 8, 1, 64'hffff_ffff_ffff_ffff);
        send_word(ACT_MASK, pack_write(1, 0, 0, 0, 0, 64'h0008, 0, 0));
        send_word(ACT_MASK, pack_write(-1, -1, 0, 0, 0, 64'h0010, 0, 0));
        for (int i = 0; i < 12; i++)
            send_read($urandom_range(15) + 16, 8'h30 + $urandom_range(1), $urandom_range(15));
        for (int i = 0; i < 24; i++)
            send_read(26'h3fffff0 + $urandom_range(15), 8'h40 + $urandom_range(1),
                      26'h3fffff0 + $urandom_range(15));
    endtask

    task automatic test_random_traffic();
        int cx, cz, sn;
        logic [7:0] ry;
        while (words_sent < WORD_TARGET)
        begin
            // long stretch with no idling in the middle
            idle_pct = (words_sent > 600 && words_sent < 850) ? 0 : 27;
            case ($urandom_range(19))
                0:
                begin
                    fill_section($urandom_range(3) - 2, $urandom_range(3) - 2,
                                 $urandom_range(15), $urandom_range(15), $urandom_range(1),
                                 $urandom_range(3) == 0 ? 300 : $urandom_range(300));
                end
                1: send_word(ACT_MASK, pack_write($urandom, $urandom, 0, 0, 0,
                                                  {$urandom, $urandom}, 0, 0));
                2:
                begin
                    // header rewrite keeps storage defined only if palette is off
                    cx = $urandom; cz = $urandom; sn = $urandom_range(15);
                    send_word(ACT_HDR, pack_write(cx, cz, sn, 0, 0,
                                                  $urandom_range(20), $urandom_range(4), 0));
                end
                3: send_word(ACT_PAL, pack_write($urandom, $urandom, $urandom, 0,
                                                 $urandom, {$urandom, $urandom}, 0, 0));
                4: send_word(ACT_WORD, pack_write($urandom, $urandom, $urandom,
                                                  $urandom_range(1023), 0,
                                                  {$urandom, $urandom}, 0, 0));
                5: send_word($urandom_range(7, 5), {$urandom, $urandom, $urandom,
                                                   $urandom, $urandom, $urandom, $urandom});
                default:
                begin
                    // half of the reads stay in the leading rows of a section
                    ry = $urandom;
                    if ($urandom_range(1) == 1)
                        ry[3:0] = 4'h0;
                    send_read(rand_coord(), ry, rand_coord());
                end
            endcase
        end
        idle_pct = 27;
    endtask

    // result side: random backpressure and in-order compare
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (lookup_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual id %h user %b",
                         $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                logic [17:0] want;
                want = lookup_q.pop_front();
                if (m_tdata !== want[15:0] || m_tuser !== want[17:16])
                begin
                    $display("%0t lookup mismatch: expected id %h err %b present %b, actual id %h err %b present %b",
                             $time, want[15:0], want[17], want[16], m_tdata, m_tuser[1], m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted word on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT && !done)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_pct = 27;
        stall_cycles = 0;
        words_sent = 0;
        done = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        for (int i = 0; i < NSECT; i++)
        begin
            ent_bits[i] = 4;
            pal_len[i] = 0;
            pal_on[i] = 0;
        end
        foreach (chunk_mask[i])
            chunk_mask[i] = 0;
        repeat (11) @(negedge clk);
        rst_n = 1;
        test_absent_sections();
        test_unpaletted_width_extremes();
        test_palette_range();
        test_random_traffic();
        s_tvalid <= 0;
        while (lookup_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        done = 1;
        if (errors == 0 && lookup_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
